// ===== design/rld_pkg.sv =====
// Package for the NTFS runlist decoder: decode phases, result kinds,
// the decoder state and result records. No dependencies.
package rld_pkg;

    // Largest length or offset field, in bytes, that the decoder accepts
    localparam int unsigned MAX_FIELD_BYTES = 8;

    localparam int unsigned RESULT_KIND_W = 3;
    localparam int unsigned WORD_W        = 64;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [RESULT_KIND_W-1:0] {
        K_RUN      = 3'd0,
        K_RUN_END  = 3'd1,
        K_TERM     = 3'd2,
        K_ZERO_LEN = 3'd3,
        K_BUF_END  = 3'd4,
        K_CUT      = 3'd5,
        K_OVERSIZE = 3'd6
    } kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [3:0]          len_left;
        logic [3:0]          off_total;
        logic [2:0]          pos;
        logic [WORD_W-1:0]   len_acc;
        logic [WORD_W-1:0]   off_acc;
        logic [WORD_W-1:0]   cluster;
    } dec_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   cluster;
        logic [WORD_W-1:0]   count;
    } result_t;

endpackage

// ===== design/rld_step.sv =====
// Per-byte decode step of the runlist decoder: next state and result.
// Depends on rld_pkg.
module rld_step
    import rld_pkg::*;
(
    input  dec_state_t  cur,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output dec_state_t  nxt,
    output logic        res_valid,
    output result_t     res
);

    logic [3:0]        lb;
    logic [3:0]        ob;
    logic [WORD_W-1:0] byte_shifted;
    logic [WORD_W-1:0] sign_mask;
    logic [WORD_W-1:0] off_full;
    logic [WORD_W-1:0] cluster_sum;
    logic [WORD_W-1:0] len_full;

    assign lb = data_byte[3:0];
    assign ob = data_byte[7:4];

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '{kind: K_RUN, cluster: '0, count: '0};

        if (first_byte)
        begin
            nxt.cluster = '0;
            nxt.phase   = PH_HEADER;
        end

        byte_shifted = {{(WORD_W-8){1'b0}}, data_byte} << {nxt.pos, 3'b000};
        sign_mask    = {WORD_W{1'b1}} << {nxt.off_total[2:0], 3'b000};
        len_full     = nxt.len_acc | byte_shifted;
        off_full     = nxt.off_acc | byte_shifted;
        if (data_byte[7] && !nxt.off_total[3])
        begin
            off_full = off_full | sign_mask;
        end
        // Offset is zero when no offset bytes exist, so the run repeats the cluster
        cluster_sum = nxt.cluster + (nxt.phase == PH_OFFSET ? off_full : nxt.off_acc);

        case (nxt.phase)
            PH_HEADER:
            begin
                nxt.len_acc = '0;
                nxt.off_acc = '0;
                nxt.pos     = '0;
                res_valid   = 1'b1;
                nxt.phase   = PH_DONE;
                if (data_byte == 8'h00)
                begin
                    res.kind = K_TERM;
                end
                else if (lb == 4'd0)
                begin
                    res.kind = K_ZERO_LEN;
                end
                else if (lb > 4'(MAX_FIELD_BYTES) || ob > 4'(MAX_FIELD_BYTES))
                begin
                    res.kind = K_OVERSIZE;
                end
                else if (last_byte)
                begin
                    res.kind = K_CUT;
                end
                else
                begin
                    res_valid     = 1'b0;
                    nxt.len_left  = lb;
                    nxt.off_total = ob;
                    nxt.phase     = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                nxt.len_acc  = len_full;
                nxt.pos      = nxt.pos + 3'd1;
                nxt.len_left = nxt.len_left - 4'd1;
                if (nxt.len_left == 4'd0 && nxt.off_total == 4'd0)
                begin
                    // Finish the run with no offset field
                    nxt.cluster = cluster_sum;
                    nxt.phase   = last_byte ? PH_DONE : PH_HEADER;
                    res_valid   = 1'b1;
                    res.kind    = last_byte ? K_RUN_END : K_RUN;
                    res.cluster = cluster_sum;
                    res.count   = len_full;
                end
                else
                begin
                    if (nxt.len_left == 4'd0)
                    begin
                        nxt.pos   = '0;
                        nxt.phase = PH_OFFSET;
                    end
                    if (last_byte)
                    begin
                        nxt.phase = PH_DONE;
                        res_valid = 1'b1;
                        res.kind  = K_CUT;
                    end
                end
            end
            PH_OFFSET:
            begin
                if (({1'b0, nxt.pos} + 4'd1) >= nxt.off_total)
                begin
                    nxt.off_acc = off_full;
                    nxt.cluster = cluster_sum;
                    nxt.phase   = last_byte ? PH_DONE : PH_HEADER;
                    res_valid   = 1'b1;
                    res.kind    = last_byte ? K_RUN_END : K_RUN;
                    res.cluster = cluster_sum;
                    res.count   = nxt.len_acc;
                end
                else
                begin
                    nxt.off_acc = nxt.off_acc | byte_shifted;
                    nxt.pos     = nxt.pos + 3'd1;
                    if (last_byte)
                    begin
                        nxt.phase = PH_DONE;
                        res_valid = 1'b1;
                        res.kind  = K_CUT;
                    end
                end
            end
            default:
            begin
                // List finished: drop bytes, report only the buffer end
                if (last_byte)
                begin
                    res_valid = 1'b1;
                    res.kind  = K_BUF_END;
                end
            end
        endcase
    end

endmodule

// ===== design/rld_out_reg.sv =====
// Result register of the runlist decoder; drains while it reloads.
// Depends on rld_pkg.
module rld_out_reg
    import rld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    take,
    output logic    can_load,
    output logic    valid,
    output result_t data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== design/ntfs_runlist_decoder.sv =====
// Pipeline: an accepted byte passes the input register, then the result
// register, i.e. two register stages. Throughput: one byte per cycle while
// the result register can load; the 64-bit cluster add in the step logic
// is the longest path. Reset clears the decode state to "expect header",
// running cluster zero, and empties both register stages.
// Depends on rld_pkg, rld_step and rld_out_reg.
module ntfs_runlist_decoder
    import rld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic [0:0]   s_tuser,    // [0] first_byte
    input  logic         s_tlast,    // last_byte
    // Run records out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // [63:0] run_cluster, [127:64] run_count
    output logic [2:0]   m_tuser     // [2:0] kind
);

    // Input register: holds one accepted byte until the step logic consumes it
    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_first_reg;
    logic       stage_last_reg;

    // Decoder state, advanced once per consumed byte
    dec_state_t state_reg;
    dec_state_t state_next;
    dec_state_t step_state;

    logic       res_valid;
    result_t    res;
    logic       out_can_load;
    logic       out_valid;
    result_t    out_data;
    logic       advance;

    // Consume the staged byte whenever the result register has room
    assign advance  = stage_valid_reg && out_can_load;
    // Accept a new byte when the stage is empty or being consumed this cycle
    assign s_tready = !stage_valid_reg || advance;

    assign stage_valid_next = s_tready ? s_tvalid : stage_valid_reg;
    assign state_next       = advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            state_reg       <= '{phase: PH_HEADER, len_left: '0, off_total: '0,
                                 pos: '0, len_acc: '0, off_acc: '0, cluster: '0};
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            state_reg       <= state_next;
        end
    end

    // Payload of the input register: load on every transaction
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stage_byte_reg  <= s_tdata;
            stage_first_reg <= s_tuser[0];
            stage_last_reg  <= s_tlast;
        end
    end

    rld_step u_step (
        .cur        (state_reg),
        .data_byte  (stage_byte_reg),
        .first_byte (stage_first_reg),
        .last_byte  (stage_last_reg),
        .nxt        (step_state),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register: only bytes that produce a record load it
    rld_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .take      (m_tready),
        .can_load  (out_can_load),
        .valid     (out_valid),
        .data      (out_data)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_data.count, out_data.cluster};
    assign m_tuser  = out_data.kind;

    // An empty input stage always takes a byte
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // A stalled result blocks the step logic
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(state_reg))
        else $error("decode state moved while result stalled");

    // Terminator and error kinds end the list
    a_term_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && (res.kind == K_TERM || res.kind == K_ZERO_LEN
            || res.kind == K_OVERSIZE || res.kind == K_CUT))
        |=> state_reg.phase == PH_DONE)
        else $error("list not closed after terminating result");

    // Records other than runs carry no cluster or count
    a_nonrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != K_RUN && m_tuser != K_RUN_END) |-> m_tdata == '0)
        else $error("non-run record carries run data");

endmodule

// ===== test/ntfs_runlist_decoder_test.sv =====
// Self-checking testbench for ntfs_runlist_decoder: random bursty byte stream in,
// run records checked against an in-bench runlist decoder model.
// Depends on rld_pkg and the decoder RTL.
module ntfs_runlist_decoder_test;
    import rld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUNLIST_BYTES = 450;
    localparam int unsigned HOLD_START    = 200;   // receiver cycle where the long stall begins
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 8;     // two register stages, plus margin
    localparam int unsigned MAX_REPORTS   = 10;

    // One byte transaction on the input stream
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } rl_byte_t;

    // How a generated runlist is closed
    typedef enum int {
        END_TERM,
        END_ZERO_LEN,
        END_OVERSIZE,
        END_RUN_LAST,
        END_CUT
    } list_end_t;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_PERIODIC
    } rx_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;     // [7:0] data_byte
    logic [0:0]   s_tuser = '0;     // [0] first_byte
    logic         s_tlast = 1'b0;   // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [63:0] run_cluster, [127:64] run_count
    logic [2:0]   m_tuser;          // [2:0] kind

    rl_byte_t pending_bytes[$];     // bytes still to be offered
    result_t  expected_runs[$];     // records the decoder owes us, oldest first
    int       stim_items = 0;
    int       error_count = 0;

    // Model state of the decoder
    phase_t       dec_phase = PH_HEADER;
    logic [3:0]   len_left = '0;
    logic [3:0]   off_total = '0;
    logic [2:0]   byte_pos = '0;
    logic [63:0]  len_acc = '0;
    logic [63:0]  off_acc = '0;
    logic [63:0]  cur_cluster = '0;

    // Sender and receiver bookkeeping
    rl_byte_t cur_byte;
    int       burst_left;
    int       gap_left;
    int       rx_cycle;
    int       seg_left;
    rx_mode_t rx_mode;

    always #5 clk = ~clk;

    ntfs_runlist_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Runlist decoder model
    // ------------------------------------------------------------------
    task automatic push_result(input kind_t kind, input logic [63:0] cl, input logic [63:0] cnt);
        result_t r;
        r.kind    = kind;
        r.cluster = cl;
        r.count   = cnt;
        expected_runs = {expected_runs, r};
    endtask

    // Add the offset to the running cluster and report the completed run
    task automatic complete_run(input logic last);
        cur_cluster = cur_cluster + off_acc;
        dec_phase   = last ? PH_DONE : PH_HEADER;
        push_result(last ? K_RUN_END : K_RUN, cur_cluster, len_acc);
    endtask

    task automatic decode_runlist_byte(input rl_byte_t item);
        logic [3:0] len_sz;
        logic [3:0] off_sz;
        int         pos;
        len_sz = item.data[3:0];
        off_sz = item.data[7:4];
        if (item.first)
        begin
            cur_cluster = '0;
            dec_phase   = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                len_acc  = '0;
                off_acc  = '0;
                byte_pos = '0;
                if (item.data == 8'h00)
                begin
                    dec_phase = PH_DONE;
                    push_result(K_TERM, '0, '0);
                end
                else if (len_sz == 4'd0)
                begin
                    dec_phase = PH_DONE;
                    push_result(K_ZERO_LEN, '0, '0);
                end
                else if (len_sz > MAX_FIELD_BYTES || off_sz > MAX_FIELD_BYTES)
                begin
                    dec_phase = PH_DONE;
                    push_result(K_OVERSIZE, '0, '0);
                end
                else if (item.last)
                begin
                    // header alone before the buffer ends: run is cut short
                    dec_phase = PH_DONE;
                    push_result(K_CUT, '0, '0);
                end
                else
                begin
                    len_left  = len_sz;
                    off_total = off_sz;
                    dec_phase = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                len_acc  = len_acc | (64'(item.data) << (8 * int'(byte_pos)));
                byte_pos = byte_pos + 3'd1;
                len_left = len_left - 4'd1;
                if (len_left == 4'd0)
                begin
                    if (off_total == 4'd0)
                    begin
                        // no offset field: run starts at the previous cluster
                        complete_run(item.last);
                        return;
                    end
                    byte_pos  = '0;
                    dec_phase = PH_OFFSET;
                end
                if (item.last)
                begin
                    dec_phase = PH_DONE;
                    push_result(K_CUT, '0, '0);
                end
            end
            PH_OFFSET:
            begin
                pos     = int'(byte_pos);
                off_acc = off_acc | (64'(item.data) << (8 * pos));
                if (pos + 1 >= int'(off_total))
                begin
                    // sign-extend a short offset from its top byte
                    if (item.data[7] && off_total < 4'd8)
                        off_acc = off_acc | ({64{1'b1}} << (8 * int'(off_total)));
                    complete_run(item.last);
                end
                else
                begin
                    byte_pos = 3'(pos + 1);
                    if (item.last)
                    begin
                        dec_phase = PH_DONE;
                        push_result(K_CUT, '0, '0);
                    end
                end
            end
            default:
            begin
                // list is over: only a buffer end is reported
                if (item.last)
                    push_result(K_BUF_END, '0, '0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] data, input logic first, input logic last);
        rl_byte_t b;
        b.data  = data;
        b.first = first;
        b.last  = last;
        pending_bytes = {pending_bytes, b};
        stim_items++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Well-formed runlist with random field sizes and content, closed in one of several ways
    task automatic add_runlist();
        int        n_runs;
        int        lb;
        int        ob;
        int        cut_at;
        int        n_pad;
        list_end_t ending;
        logic      last_run;
        n_runs = $urandom_range(1, 5);
        ending = list_end_t'($urandom_range(0, 4));
        for (int r = 0; r < n_runs; r++)
        begin
            lb = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 3);
            ob = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 4);
            last_run = (r == n_runs - 1);
            cut_at = (last_run && ending == END_CUT) ? $urandom_range(0, lb + ob - 1) : -1;
            add_byte(8'((ob << 4) | lb), r == 0, cut_at == 0);
            for (int k = 1; k <= lb + ob && cut_at != 0; k++)
            begin
                add_byte(rand_byte(), 1'b0,
                         (k == cut_at) || (last_run && ending == END_RUN_LAST && k == lb + ob));
                if (k == cut_at)
                    break;
            end
        end
        case (ending)
            END_TERM:
                add_byte(8'h00, 1'b0, 1'($urandom_range(0, 1)));
            END_ZERO_LEN:
                add_byte(8'($urandom_range(1, 15) << 4), 1'b0, 1'($urandom_range(0, 1)));
            END_OVERSIZE:
                if ($urandom_range(0, 1) == 1)
                    add_byte(8'(($urandom_range(0, 15) << 4) | $urandom_range(9, 15)),
                             1'b0, 1'($urandom_range(0, 1)));
                else
                    add_byte(8'(($urandom_range(9, 15) << 4) | $urandom_range(1, 15)),
                             1'b0, 1'($urandom_range(0, 1)));
            default:
                ;
        endcase
        // trailing bytes after the list is done; the decoder drops them
        n_pad = $urandom_range(0, 2);
        for (int k = 0; k < n_pad; k++)
            add_byte(rand_byte(), 1'b0, (k == n_pad - 1) && ($urandom_range(0, 1) == 1));
    endtask

    // Raw noise: random bytes with random list starts and buffer ends
    task automatic add_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
            add_byte(rand_byte(), $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of transactions with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_runlist_byte(cur_byte);
            // hold the current byte while it is stalled
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    cur_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_byte.data;
                    s_tuser  <= cur_byte.first;
                    s_tlast  <= cur_byte.last;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes per segment, plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            seg_left = 0;
            rx_mode  = RX_ALWAYS;
        end
        else
        begin
            rx_cycle++;
            if (seg_left == 0)
            begin
                rx_mode  = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 120);
            end
            else
                seg_left--;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;   // long back-pressure: let the decoder fill up
            else
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ((rx_cycle % 3) != 0);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_run;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_runs.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("Unexpected record: kind %0d cluster %h count %h",
                             m_tuser, m_tdata[63:0], m_tdata[127:64]);
                error_count++;
            end
            else
            begin
                exp_run = expected_runs.pop_front();
                if (m_tuser !== exp_run.kind || m_tdata[63:0] !== exp_run.cluster
                    || m_tdata[127:64] !== exp_run.count)
                begin
                    if (error_count < MAX_REPORTS)
                    begin
                        $display("Mismatch: expected kind %0d cluster %h count %h",
                                 exp_run.kind, exp_run.cluster, exp_run.count);
                        $display("          got kind %0d cluster %h count %h",
                                 m_tuser, m_tdata[63:0], m_tdata[127:64]);
                    end
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: terminator, ignored bytes and buffer end after it
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);
        add_byte(8'hA5, 1'b0, 1'b1);
        // Oversize offset and oversize length
        add_byte(8'hF1, 1'b1, 1'b0);
        add_byte(8'h19, 1'b1, 1'b0);
        // Zero length size
        add_byte(8'h10, 1'b1, 1'b0);
        // Negative two-byte offset, then a run with no offset field
        add_byte(8'h21, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h03, 1'b0, 1'b0);
        // Buffer ends on a bare header
        add_byte(8'h11, 1'b0, 1'b1);
        // Buffer ends inside the length field
        add_byte(8'h12, 1'b1, 1'b0);
        add_byte(8'h01, 1'b0, 1'b1);
        // Buffer ends exactly on a complete run
        add_byte(8'h11, 1'b1, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b1);
        // Buffer ends inside the offset field
        add_byte(8'h21, 1'b1, 1'b0);
        add_byte(8'h02, 1'b0, 1'b0);
        add_byte(8'h34, 1'b0, 1'b1);

        // Random part: mostly well-formed lists, some noise
        while (stim_items < RUNLIST_BYTES)
        begin
            if ($urandom_range(0, 9) < 8)
                add_runlist();
            else
                add_noise();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every byte accepted, every record received
        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_runs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rld_pkg.sv
design/rld_step.sv
design/rld_out_reg.sv
design/ntfs_runlist_decoder.sv
test/ntfs_runlist_decoder_test.sv
